// ----- rtl/core/tlh_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tlh_pkg
// Shared codes, byte constants and control types of the text line hasher.
// ----------------------------------------------------------------------------
package tlh_pkg;

    localparam int unsigned KEY_W = 32;

    // Input operation codes
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_END  = 1'b1;

    // Result kinds
    localparam logic KIND_LINE    = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    // Byte values of interest
    localparam logic [7:0] BYTE_NUL = 8'h00;
    localparam logic [7:0] BYTE_TAB = 8'h09;
    localparam logic [7:0] BYTE_NL  = 8'h0A;
    localparam logic [7:0] BYTE_VT  = 8'h0B;
    localparam logic [7:0] BYTE_FF  = 8'h0C;
    localparam logic [7:0] BYTE_CR  = 8'h0D;
    localparam logic [7:0] BYTE_SP  = 8'h20;

    // Result queue geometry
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W      = 2;
    localparam int unsigned QCNT_W      = 3;

    // Pushes from the line core into the result queue
    typedef struct packed {
        logic push_a;   // first slot: line record
        logic push_b;   // second slot: end-of-text summary
    } t_push_ctl;

    function automatic logic is_trim_space(input logic [7:0] b);
        return (b == BYTE_SP) || (b == BYTE_TAB) || (b == BYTE_VT) ||
               (b == BYTE_FF) || (b == BYTE_CR);
    endfunction

endpackage
`default_nettype wire

// ----- rtl/core/tlh_line_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tlh_line_core
// Input register, line state and one-pass hash/trim update; builds records.
// ----------------------------------------------------------------------------
module tlh_line_core
    import tlh_pkg::*;
#(
    parameter int unsigned LENGTH_BITS = 13,
    parameter int unsigned COUNT_BITS  = 16,
    localparam int unsigned REC_W = 1 + KEY_W + LENGTH_BITS + COUNT_BITS + 1 + 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_ready,
    input  wire logic             i_op,
    input  wire logic [7:0]       i_text_byte,
    input  wire logic             i_room,
    output t_push_ctl             o_push,
    output logic [REC_W-1:0]      o_rec_a,
    output logic [REC_W-1:0]      o_rec_b
);

    localparam int unsigned RAW_W = LENGTH_BITS + 1;

    logic                   r_in_valid;
    logic                   r_in_op;
    logic [7:0]             r_in_byte;

    logic [KEY_W-1:0]       r_run_hash, n_run_hash;
    logic [KEY_W-1:0]       r_com_hash, n_com_hash;
    logic [RAW_W-1:0]       r_raw_len,  n_raw_len;
    logic [LENGTH_BITS-1:0] r_kept_len, n_kept_len;
    logic [COUNT_BITS-1:0]  r_count,    n_count;
    logic                   r_bin,      n_bin;

    logic                   process;
    logic [KEY_W-1:0]       byte_sext;
    logic [KEY_W-1:0]       hash_upd;
    logic [RAW_W-1:0]       raw_upd;
    logic                   over;
    logic [COUNT_BITS-1:0]  count_inc;
    logic [KEY_W-1:0]       line_key;
    logic                   need_line;

    assign process = r_in_valid && i_room;
    assign o_ready = !r_in_valid || i_room;

    assign byte_sext = {{(KEY_W-8){r_in_byte[7]}}, r_in_byte};
    assign hash_upd  = r_run_hash ^ (r_run_hash << 2) ^ byte_sext;
    assign raw_upd   = (&r_raw_len) ? r_raw_len : r_raw_len + RAW_W'(1);
    assign over      = raw_upd[LENGTH_BITS];
    assign count_inc = (&r_count) ? r_count : r_count + COUNT_BITS'(1);
    assign line_key  = {r_com_hash[KEY_W-LENGTH_BITS-1:0], r_kept_len};
    assign need_line = (r_raw_len != '0) || (r_count == '0);

    always_comb begin
        n_run_hash = r_run_hash;
        n_com_hash = r_com_hash;
        n_raw_len  = r_raw_len;
        n_kept_len = r_kept_len;
        n_count    = r_count;
        n_bin      = r_bin;
        o_push     = '{push_a: 1'b0, push_b: 1'b0};
        o_rec_a    = {KIND_LINE, line_key, r_kept_len, r_count, r_bin, 1'b1};
        o_rec_b    = {KIND_SUMMARY, {KEY_W{1'b0}}, {LENGTH_BITS{1'b0}},
                      need_line ? count_inc : r_count, r_bin, 1'b1};
        if (process) begin
            if (r_in_op == OP_END) begin
                // Flush pending line (or the lone empty line), then summary
                o_push.push_a = need_line;
                o_push.push_b = 1'b1;
                o_rec_a[0]    = 1'b0;
                n_run_hash    = '0;
                n_com_hash    = '0;
                n_raw_len     = '0;
                n_kept_len    = '0;
                n_count       = '0;
                n_bin         = 1'b0;
            end else if (r_in_byte == BYTE_NL) begin
                o_push.push_a = 1'b1;
                n_count       = count_inc;
                n_run_hash    = '0;
                n_com_hash    = '0;
                n_raw_len     = '0;
                n_kept_len    = '0;
            end else begin
                n_run_hash = hash_upd;
                n_raw_len  = raw_upd;
                if ((r_in_byte == BYTE_NUL) || over) begin
                    n_bin = 1'b1;
                end
                if (!is_trim_space(r_in_byte)) begin
                    n_com_hash = hash_upd;
                    n_kept_len = over ? {LENGTH_BITS{1'b1}} : raw_upd[LENGTH_BITS-1:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_run_hash <= '0;
            r_com_hash <= '0;
            r_raw_len  <= '0;
            r_kept_len <= '0;
            r_count    <= '0;
            r_bin      <= 1'b0;
        end else begin
            if (o_ready) begin
                r_in_valid <= i_valid;
            end
            r_run_hash <= n_run_hash;
            r_com_hash <= n_com_hash;
            r_raw_len  <= n_raw_len;
            r_kept_len <= n_kept_len;
            r_count    <= n_count;
            r_bin      <= n_bin;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_op   <= i_op;
            r_in_byte <= i_text_byte;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/core/tlh_result_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tlh_result_queue
// Small result queue: up to two pushes and one pop per cycle.
// ----------------------------------------------------------------------------
module tlh_result_queue
    import tlh_pkg::*;
#(
    parameter int unsigned WIDTH = 64
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_push_ctl        i_push,
    input  wire logic [WIDTH-1:0] i_rec_a,
    input  wire logic [WIDTH-1:0] i_rec_b,
    output logic                  o_room,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output logic [WIDTH-1:0]      o_rec
);

    logic [WIDTH-1:0]  r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic [QPTR_W-1:0] wr_b;
    logic              pop;

    assign o_valid = (r_count != '0);
    assign o_rec   = r_mem[r_rd_ptr];
    assign pop     = o_valid && i_ready;
    // Leave space for the worst case of two pushes
    assign o_room  = (r_count <= QCNT_W'(QUEUE_DEPTH - 2));
    assign wr_b    = r_wr_ptr + QPTR_W'(i_push.push_a);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + QPTR_W'(i_push.push_a) + QPTR_W'(i_push.push_b);
            r_rd_ptr <= r_rd_ptr + QPTR_W'(pop);
            r_count  <= r_count + QCNT_W'(i_push.push_a) + QCNT_W'(i_push.push_b)
                        - QCNT_W'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.push_a) begin
            r_mem[r_wr_ptr] <= i_rec_a;
        end
        if (i_push.push_b) begin
            r_mem[wr_b] <= i_rec_b;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/core/text_line_hasher.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// text_line_hasher
// Splits a byte stream into lines and emits one hashed key per line.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid/o_ready) carries one transfer per text byte
//   (i_op = byte) or an end-of-text marker (i_op = end). Output channel
//   (o_valid/i_ready) carries line records and the end-of-text summary.
//   A newline gives one record; end of text gives the pending line (or one
//   empty line for empty text) followed by a summary with the line count.
//   The final result caused by an input transfer has o_last set.
// Timing:
//   One input transfer per cycle while the queue has room. A result is
//   presented once its input transfer has passed the input register: the item
//   sits in the input register and goes through the hash/trim update into
//   the result queue. End of text gives two results; the four-entry
//   queue absorbs them and input is held off only when fewer than two slots
//   are free.
// Reset:
//   Clears hash, lengths, line count, binary flag and the queue; the next
//   byte starts a new text.
// Stall:
//   When i_ready is low results wait in the queue; once it cannot take the
//   worst case of two more results, o_ready drops and the input holds.
// ----------------------------------------------------------------------------
module text_line_hasher
    import tlh_pkg::*;
#(
    parameter int unsigned LENGTH_BITS = 13,
    parameter int unsigned COUNT_BITS  = 16
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_valid,
    output logic                        o_ready,
    input  wire logic                   i_op,
    input  wire logic [7:0]             i_text_byte,
    output logic                        o_valid,
    input  wire logic                   i_ready,
    output logic                        o_kind,
    output logic [KEY_W-1:0]            o_line_key,
    output logic [LENGTH_BITS-1:0]      o_trimmed_length,
    output logic [COUNT_BITS-1:0]       o_line_number,
    output logic                        o_binary_text,
    output logic                        o_last
);

    localparam int unsigned REC_W = 1 + KEY_W + LENGTH_BITS + COUNT_BITS + 1 + 1;

    t_push_ctl        push;
    logic [REC_W-1:0] rec_a;
    logic [REC_W-1:0] rec_b;
    logic [REC_W-1:0] rec_out;
    logic             room;

    // Input register plus line state: one byte per cycle while the queue has room
    tlh_line_core #(
        .LENGTH_BITS (LENGTH_BITS),
        .COUNT_BITS  (COUNT_BITS)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_op        (i_op),
        .i_text_byte (i_text_byte),
        .i_room      (room),
        .o_push      (push),
        .o_rec_a     (rec_a),
        .o_rec_b     (rec_b)
    );

    // Hold results until the receiver takes them
    tlh_result_queue #(
        .WIDTH (REC_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_rec_a (rec_a),
        .i_rec_b (rec_b),
        .o_room  (room),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_rec   (rec_out)
    );

    // Unpack {kind, key, length, number, binary, last}
    assign {o_kind, o_line_key, o_trimmed_length, o_line_number,
            o_binary_text, o_last} = rec_out;

endmodule
`default_nettype wire
